// ===== design/elapsed_time_stopwatch_assert.svh =====
`ifndef ELAPSED_TIME_STOPWATCH_ASSERT_SVH
`define ELAPSED_TIME_STOPWATCH_ASSERT_SVH

// Condition must hold in the same cycle as its trigger
`define ETS_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("stopwatch check failed");

// Condition must hold in the cycle after its trigger
`define ETS_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("stopwatch check failed");

`endif

// ===== design/ets_pkg.sv =====
package ets_pkg;

    // Port widths
    localparam int unsigned NOW_W          = 32;
    localparam int unsigned TIME_WIDTH_DEF = 32;
    localparam int unsigned SHOWN_W        = 14;
    localparam int unsigned SHOWN_MAX      = 9959;

    // Elapsed time is first folded to a residue modulo one hundred hours
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WRAP_SECS = 360000;
    localparam int unsigned RES_W     = 19;
    localparam int unsigned PROD_W    = BYTE_W + RES_W;
    localparam int unsigned SUM_W     = 30;

    // Quotient of the folded sum by WRAP_SECS: drop six bits, then divide by 5625
    localparam int unsigned SUM_SHIFT  = 6;
    localparam int unsigned QUOT_DIV   = WRAP_SECS >> SUM_SHIFT;
    localparam int unsigned T_W        = SUM_W - SUM_SHIFT;
    localparam int unsigned Q_SHIFT    = 38;
    localparam int unsigned Q_RECIP_W  = 26;
    localparam int unsigned Q_W        = 12;
    localparam logic [Q_RECIP_W-1:0] Q_RECIP =
        Q_RECIP_W'(((64'd1 << Q_SHIFT) + QUOT_DIV - 1) / QUOT_DIV);

    // Hours: drop four bits, then divide by 225
    localparam int unsigned SECS_HOUR  = 3600;
    localparam int unsigned HOUR_PRE   = 4;
    localparam int unsigned HOUR_DIV   = SECS_HOUR >> HOUR_PRE;
    localparam int unsigned H_SHIFT    = 23;
    localparam int unsigned H_RECIP_W  = 16;
    localparam int unsigned HOUR_W     = 7;
    localparam logic [H_RECIP_W-1:0] H_RECIP =
        H_RECIP_W'(((64'd1 << H_SHIFT) + HOUR_DIV - 1) / HOUR_DIV);

    // Minutes: drop two bits, then divide by 15
    localparam int unsigned SECS_MIN   = 60;
    localparam int unsigned REM_W      = 12;
    localparam int unsigned MIN_PRE    = 2;
    localparam int unsigned MIN_DIV    = SECS_MIN >> MIN_PRE;
    localparam int unsigned M_SHIFT    = 14;
    localparam int unsigned M_RECIP_W  = 11;
    localparam int unsigned MIN_W      = 6;
    localparam logic [M_RECIP_W-1:0] M_RECIP =
        M_RECIP_W'(((64'd1 << M_SHIFT) + MIN_DIV - 1) / MIN_DIV);

    localparam int unsigned HOUR_WRAP = 100;

    localparam logic [RES_W-1:0]  WRAP_SECS_C = RES_W'(WRAP_SECS);
    localparam logic [REM_W-1:0]  SECS_HOUR_C = REM_W'(SECS_HOUR);
    localparam logic [HOUR_W-1:0] HOUR_WRAP_C = HOUR_W'(HOUR_WRAP);

    // What travels with each request through the pipeline
    typedef struct packed {
        logic show_held;
        logic colon;
    } ets_tag_t;

    // Weight of byte idx of the elapsed time, modulo WRAP_SECS
    function automatic logic [RES_W-1:0] fold_weight(input int unsigned idx);
        longint unsigned w;
        w = 1;
        for (int unsigned k = 0; k < idx; k++)
        begin
            w = (w * 256) % WRAP_SECS;
        end
        return RES_W'(w);
    endfunction

endpackage

// ===== design/elapsed_time_stopwatch.sv =====
// Elapsed-time stopwatch with an hours:minutes display value.
// Request channel (req_valid/req_stall): current time in seconds and the
// start and stop button levels, both low when pressed. A request is taken
// on a rising edge with req_valid high and req_stall low.
// Result channel (rsp_valid/rsp_stall): shown_value = hours*100+minutes and
// colon_on. A request gives one result when stop is pressed or the watch is
// running, and none otherwise.
// A request passes the job, fold product, fold sum, div a to d and
// result registers. Throughput: one request per cycle while not
// stalled, set by the eight-stage pipeline (byte fold, then three
// reciprocal multiplies for the hundred-hour residue, hours and minutes).
// Reset: watch stopped, start seen as released, held display value zero,
// pipeline empty.
// With a valid result and rsp_stall high the result register holds;
// stages behind it keep filling bubbles, and req_stall rises once the
// first stage is full and blocked.
`include "elapsed_time_stopwatch_assert.svh"

module elapsed_time_stopwatch
    import ets_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [NOW_W-1:0]   now_seconds,
    input  logic               start_level,
    input  logic               stop_level,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [SHOWN_W-1:0] shown_value,
    output logic               colon_on
);

    logic                  job_valid;
    logic                  job_stall;
    logic [TIME_WIDTH-1:0] job_elapsed;
    ets_tag_t              job_tag;
    logic                  fold_valid;
    logic                  fold_stall;
    logic [SUM_W-1:0]      fold_sum;
    ets_tag_t              fold_tag;
    logic                  div_valid;
    logic                  div_stall;
    logic [REM_W-1:0]      div_rem;
    logic [SHOWN_W-1:0]    div_hund;
    ets_tag_t              div_tag;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic [SHOWN_W-1:0]    shown_reg, shown_next;
    logic                  colon_reg, colon_next;
    logic [SHOWN_W-1:0]    held_reg, held_next;

    logic                  out_take;
    logic [REM_W-MIN_PRE+M_RECIP_W-1:0] m_prod;
    logic [MIN_W-1:0]      minutes;
    logic [SHOWN_W-1:0]    calc_shown;

    ets_ctrl #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .now_seconds (now_seconds),
        .start_level (start_level),
        .stop_level  (stop_level),
        .job_valid   (job_valid),
        .job_stall   (job_stall),
        .job_elapsed (job_elapsed),
        .job_tag     (job_tag)
    );

    ets_fold #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_fold (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_stall   (job_stall),
        .job_elapsed (job_elapsed),
        .job_tag     (job_tag),
        .fold_valid  (fold_valid),
        .fold_stall  (fold_stall),
        .fold_sum    (fold_sum),
        .fold_tag    (fold_tag)
    );

    ets_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .fold_valid (fold_valid),
        .fold_stall (fold_stall),
        .fold_sum   (fold_sum),
        .fold_tag   (fold_tag),
        .div_valid  (div_valid),
        .div_stall  (div_stall),
        .div_rem    (div_rem),
        .div_hund   (div_hund),
        .div_tag    (div_tag)
    );

    assign out_take  = !rsp_valid_reg || !rsp_stall;
    assign div_stall = !out_take;

    // Finish the minutes and pick the held or freshly computed value
    always_comb
    begin
        m_prod     = div_rem[REM_W-1:MIN_PRE] * M_RECIP;
        minutes    = m_prod[M_SHIFT +: MIN_W];
        calc_shown = div_hund + SHOWN_W'(minutes);

        shown_next     = div_tag.show_held ? held_reg : calc_shown;
        colon_next     = div_tag.colon;
        rsp_valid_next = out_take ? div_valid : rsp_valid_reg;
        held_next      = held_reg;
        if (out_take && div_valid && !div_tag.show_held)
        begin
            held_next = calc_shown;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            held_reg      <= held_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            shown_reg <= shown_next;
            colon_reg <= colon_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign shown_value = shown_reg;
    assign colon_on    = colon_reg;

    `ETS_ASSERT_SAME(a_held_range, 1'b1, held_reg <= SHOWN_W'(SHOWN_MAX))
    `ETS_ASSERT_SAME(a_held_shown, !$stable(held_reg), rsp_valid_reg && shown_reg == held_reg)
    `ETS_ASSERT_SAME(a_stall_full, req_stall, job_valid)
    `ETS_ASSERT_NEXT(a_stop_emits, req_valid && !req_stall && !stop_level, job_valid)

endmodule

// ===== design/ets_ctrl.sv =====
module ets_ctrl
    import ets_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [NOW_W-1:0]      now_seconds,
    input  logic                  start_level,
    input  logic                  stop_level,
    output logic                  job_valid,
    input  logic                  job_stall,
    output logic [TIME_WIDTH-1:0] job_elapsed,
    output ets_tag_t              job_tag
);

    logic                  last_start_reg, last_start_next;
    logic                  running_reg, running_next;
    logic [TIME_WIDTH-1:0] stamp_reg, stamp_next;
    logic                  job_valid_reg, job_valid_next;
    logic [TIME_WIDTH-1:0] elapsed_reg, elapsed_next;
    ets_tag_t              tag_reg, tag_next;

    logic                  job_take;
    logic                  accept;
    logic                  start_edge;
    logic                  run_now;
    logic [TIME_WIDTH-1:0] now_w;

    assign job_take  = !job_valid_reg || !job_stall;
    assign req_stall = !job_take;
    assign accept    = req_valid && job_take;
    assign now_w     = TIME_WIDTH'(now_seconds);

    // Decode the buttons and form the elapsed time
    always_comb
    begin
        start_edge      = !start_level && last_start_reg && !running_reg;
        run_now         = running_reg || start_edge;
        stamp_next      = start_edge ? now_w : stamp_reg;
        elapsed_next    = now_w - stamp_next;
        last_start_next = start_level;
        running_next    = run_now && stop_level;

        tag_next.show_held = !stop_level;
        tag_next.colon     = !stop_level || !elapsed_next[0];

        job_valid_next = job_valid_reg;
        if (job_take)
        begin
            job_valid_next = accept && (!stop_level || run_now);
        end
    end

    // Hold the button and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_start_reg <= 1'b1;
            running_reg    <= 1'b0;
            stamp_reg      <= '0;
            job_valid_reg  <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            if (accept)
            begin
                last_start_reg <= last_start_next;
                running_reg    <= running_next;
                stamp_reg      <= stamp_next;
            end
        end
    end

    // Advance the request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            elapsed_reg <= elapsed_next;
            tag_reg     <= tag_next;
        end
    end

    assign job_valid   = job_valid_reg;
    assign job_elapsed = elapsed_reg;
    assign job_tag     = tag_reg;

endmodule

// ===== design/ets_fold.sv =====
module ets_fold
    import ets_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_stall,
    input  logic [TIME_WIDTH-1:0] job_elapsed,
    input  ets_tag_t              job_tag,
    output logic                  fold_valid,
    input  logic                  fold_stall,
    output logic [SUM_W-1:0]      fold_sum,
    output ets_tag_t              fold_tag
);

    localparam int unsigned NCH  = (TIME_WIDTH + BYTE_W - 1) / BYTE_W;
    localparam int unsigned PADW = NCH * BYTE_W;

    logic              prod_valid_reg, prod_valid_next;
    logic [PROD_W-1:0] prod_reg [NCH];
    logic [PROD_W-1:0] prod_next [NCH];
    ets_tag_t          prod_tag_reg;
    logic              sum_valid_reg, sum_valid_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    ets_tag_t          sum_tag_reg;

    logic              sum_take;
    logic              prod_take;
    logic [PADW-1:0]   e_pad;

    assign sum_take  = !sum_valid_reg || !fold_stall;
    assign prod_take = !prod_valid_reg || sum_take;
    assign job_stall = !prod_take;
    assign e_pad     = PADW'(job_elapsed);

    // Weight each byte of the elapsed time by its residue
    for (genvar i = 0; i < NCH; i++)
    begin : g_lane
        localparam logic [RES_W-1:0] WEIGHT = fold_weight(i);
        assign prod_next[i] = e_pad[i*BYTE_W +: BYTE_W] * WEIGHT;
    end

    // Add the weighted bytes
    always_comb
    begin
        sum_next = '0;
        for (int unsigned i = 0; i < NCH; i++)
        begin
            sum_next = sum_next + SUM_W'(prod_reg[i]);
        end
        prod_valid_next = prod_take ? job_valid : prod_valid_reg;
        sum_valid_next  = sum_take ? prod_valid_reg : sum_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            sum_valid_reg  <= sum_valid_next;
        end
    end

    // Advance the payload stages
    always_ff @(posedge clk)
    begin
        if (prod_take)
        begin
            prod_reg     <= prod_next;
            prod_tag_reg <= job_tag;
        end
        if (sum_take)
        begin
            sum_reg     <= sum_next;
            sum_tag_reg <= prod_tag_reg;
        end
    end

    assign fold_valid = sum_valid_reg;
    assign fold_sum   = sum_reg;
    assign fold_tag   = sum_tag_reg;

endmodule

// ===== design/ets_div.sv =====
module ets_div
    import ets_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fold_valid,
    output logic               fold_stall,
    input  logic [SUM_W-1:0]   fold_sum,
    input  ets_tag_t           fold_tag,
    output logic               div_valid,
    input  logic               div_stall,
    output logic [REM_W-1:0]   div_rem,
    output logic [SHOWN_W-1:0] div_hund,
    output ets_tag_t           div_tag
);

    // Stage a: quotient by WRAP_SECS
    logic                 a_valid_reg, a_valid_next;
    logic [Q_W-1:0]       a_quot_reg, a_quot_next;
    logic [RES_W-1:0]     a_low_reg;
    ets_tag_t             a_tag_reg;
    // Stage b: residue
    logic                 b_valid_reg, b_valid_next;
    logic [RES_W-1:0]     b_res_reg, b_res_next;
    ets_tag_t             b_tag_reg;
    // Stage c: hours
    logic                 c_valid_reg, c_valid_next;
    logic [HOUR_W-1:0]    c_hrs_reg, c_hrs_next;
    logic [RES_W-1:0]     c_res_reg;
    ets_tag_t             c_tag_reg;
    // Stage d: seconds within the hour and hours times one hundred
    logic                 d_valid_reg, d_valid_next;
    logic [REM_W-1:0]     d_rem_reg, d_rem_next;
    logic [SHOWN_W-1:0]   d_hund_reg, d_hund_next;
    ets_tag_t             d_tag_reg;

    logic a_take, b_take, c_take, d_take;

    logic [T_W+Q_RECIP_W-1:0]           q_prod;
    logic [Q_W+RES_W-1:0]               q_secs;
    logic [RES_W-HOUR_PRE+H_RECIP_W-1:0] h_prod;
    logic [HOUR_W+REM_W-1:0]            h_secs;

    assign d_take     = !d_valid_reg || !div_stall;
    assign c_take     = !c_valid_reg || d_take;
    assign b_take     = !b_valid_reg || c_take;
    assign a_take     = !a_valid_reg || b_take;
    assign fold_stall = !a_take;

    // Divide by reciprocal multiplication, the products spread over stages a to d
    always_comb
    begin
        q_prod      = fold_sum[SUM_W-1:SUM_SHIFT] * Q_RECIP;
        a_quot_next = q_prod[Q_SHIFT +: Q_W];

        q_secs      = a_quot_reg * WRAP_SECS_C;
        b_res_next  = a_low_reg - q_secs[RES_W-1:0];

        h_prod      = b_res_reg[RES_W-1:HOUR_PRE] * H_RECIP;
        c_hrs_next  = h_prod[H_SHIFT +: HOUR_W];

        h_secs      = c_hrs_reg * SECS_HOUR_C;
        d_rem_next  = REM_W'(c_res_reg - RES_W'(h_secs));
        d_hund_next = c_hrs_reg * HOUR_WRAP_C;

        a_valid_next = a_take ? fold_valid : a_valid_reg;
        b_valid_next = b_take ? a_valid_reg : b_valid_reg;
        c_valid_next = c_take ? b_valid_reg : c_valid_reg;
        d_valid_next = d_take ? c_valid_reg : d_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    // Advance the payload stages
    always_ff @(posedge clk)
    begin
        if (a_take)
        begin
            a_quot_reg <= a_quot_next;
            a_low_reg  <= fold_sum[RES_W-1:0];
            a_tag_reg  <= fold_tag;
        end
        if (b_take)
        begin
            b_res_reg <= b_res_next;
            b_tag_reg <= a_tag_reg;
        end
        if (c_take)
        begin
            c_hrs_reg <= c_hrs_next;
            c_res_reg <= b_res_reg;
            c_tag_reg <= b_tag_reg;
        end
        if (d_take)
        begin
            d_rem_reg  <= d_rem_next;
            d_hund_reg <= d_hund_next;
            d_tag_reg  <= c_tag_reg;
        end
    end

    assign div_valid = d_valid_reg;
    assign div_rem   = d_rem_reg;
    assign div_hund  = d_hund_reg;
    assign div_tag   = d_tag_reg;

endmodule

// ===== tb/sv/elapsed_time_stopwatch_checker.sv =====
module elapsed_time_stopwatch_checker
    import ets_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  logic [NOW_W-1:0]   now_seconds,
    input  logic               start_level,
    input  logic               stop_level,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  logic [SHOWN_W-1:0] shown_value,
    input  logic               colon_on,
    output int                 fail_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SHOWN_W-1:0] value;
        logic               colon;
    } display_t;

    // Own copy of the watch state
    logic               prev_start;
    logic               running;
    logic [NOW_W-1:0]   start_stamp;
    logic [HOUR_W-1:0]  held_hours;
    logic [MIN_W-1:0]   held_minutes;

    display_t due_displays[$];

    function automatic logic [SHOWN_W-1:0] held_value();
        return SHOWN_W'(held_hours * HOUR_WRAP + held_minutes);
    endfunction

    // Advance the watch by one request; return 1 when it puts something on the display
    function automatic bit predict_display(input logic [NOW_W-1:0] now, input logic start,
                                           input logic stop, output display_t shown);
        logic [NOW_W-1:0] elapsed;
        shown = '0;
        // latch the start time on a fresh press while stopped
        if (!start && prev_start && !running)
        begin
            start_stamp = now;
            running     = 1'b1;
        end
        prev_start = start;
        // stop wins: show what is held, colon lit
        if (!stop)
        begin
            running     = 1'b0;
            shown.value = held_value();
            shown.colon = 1'b1;
            return 1'b1;
        end
        if (running)
        begin
            elapsed      = now - start_stamp;
            held_hours   = HOUR_W'((elapsed / SECS_HOUR) % HOUR_WRAP);
            held_minutes = MIN_W'((elapsed % SECS_HOUR) / SECS_MIN);
            shown.value  = held_value();
            shown.colon  = ~elapsed[0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_display
        display_t shown;
        display_t due;
        int       errs;
        if (!rst_n)
        begin
            prev_start    = 1'b1;
            running       = 1'b0;
            start_stamp   = '0;
            held_hours    = '0;
            held_minutes  = '0;
            due_displays.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            errs = 0;
            // compare a delivered result against the oldest one due
            if (rsp_valid && !rsp_stall)
            begin
                if (due_displays.size() == 0)
                begin
                    $error("unexpected result: shown_value %0d colon_on %0b",
                           shown_value, colon_on);
                    errs++;
                end
                else
                begin
                    due = due_displays.pop_front();
                    if (shown_value !== due.value)
                    begin
                        $error("shown_value: expected %0d, got %0d", due.value, shown_value);
                        errs++;
                    end
                    if (colon_on !== due.colon)
                    begin
                        $error("colon_on: expected %0b, got %0b", due.colon, colon_on);
                        errs++;
                    end
                end
            end
            // predict from each accepted request
            if (req_valid && !req_stall &&
                predict_display(now_seconds, start_level, stop_level, shown))
            begin
                due_displays.push_back(shown);
            end
            fail_count    <= fail_count + errs;
            pending_count <= due_displays.size();
        end
    end

endmodule

// ===== tb/sv/elapsed_time_stopwatch_tb.sv =====
module elapsed_time_stopwatch_tb;
    import ets_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic        PRESSED      = 1'b0;
    localparam logic        RELEASED     = 1'b1;
    localparam int unsigned PHASE_ITEMS  = 300;
    localparam int unsigned DRAIN_CYCLES = 20;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               req_valid   = 1'b0;
    logic               req_stall;
    logic [NOW_W-1:0]   now_seconds = '0;
    logic               start_level = 1'b1;
    logic               stop_level  = 1'b1;
    logic               rsp_valid;
    logic               rsp_stall   = 1'b0;
    logic [SHOWN_W-1:0] shown_value;
    logic               colon_on;

    int          fail_count;
    int          pending_count;
    int unsigned idle_pct      = 0;
    int unsigned stall_pct     = 0;
    int unsigned requests_sent = 0;

    always #5 clk = ~clk;

    elapsed_time_stopwatch i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .now_seconds (now_seconds),
        .start_level (start_level),
        .stop_level  (stop_level),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .shown_value (shown_value),
        .colon_on    (colon_on)
    );

    elapsed_time_stopwatch_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .now_seconds   (now_seconds),
        .start_level   (start_level),
        .stop_level    (stop_level),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .shown_value   (shown_value),
        .colon_on      (colon_on),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Stall the result side at random
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // Drive one request; entered and left at a falling edge
    task automatic send_request(input logic [NOW_W-1:0] now, input logic start,
                                input logic stop);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        now_seconds <= now;
        start_level <= start;
        stop_level  <= stop;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    function automatic logic [NOW_W-1:0] time_step();
        case ($urandom_range(3))
            0:       return NOW_W'($urandom_range(3));
            1:       return NOW_W'($urandom_range(7200));
            2:       return NOW_W'($urandom_range(400000));
            default: return NOW_W'($urandom());
        endcase
    endfunction

    // Release, press start, run for a while, then mostly press stop
    task automatic watch_session();
        logic [NOW_W-1:0] t;
        int unsigned      runs;
        if ($urandom_range(3) == 0)
            t = 32'hFFFF_FFFF - NOW_W'($urandom_range(400000));
        else
            t = NOW_W'($urandom());
        send_request(t - NOW_W'($urandom_range(60)), RELEASED, RELEASED);
        send_request(t, PRESSED, RELEASED);
        runs = $urandom_range(1, 12);
        repeat (runs)
        begin
            t = t + time_step();
            send_request(t, ($urandom_range(3) == 0) ? PRESSED : RELEASED, RELEASED);
        end
        if ($urandom_range(4) != 0)
            send_request(t + NOW_W'($urandom_range(5)), 1'($urandom_range(1)), PRESSED);
    endtask

    task automatic run_phase(input int unsigned idle, input int unsigned stall);
        int unsigned target;
        idle_pct  = idle;
        stall_pct = stall;
        target    = requests_sent + PHASE_ITEMS;
        while (requests_sent < target)
        begin
            // mostly proper sessions, some noise
            if ($urandom_range(99) < 15)
                send_request(NOW_W'($urandom()), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
            else
                watch_session();
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // stopped with no stop press: nothing shown
        send_request(32'd0, RELEASED, RELEASED);
        // stop while stopped: zero, colon lit
        send_request(32'd1, RELEASED, PRESSED);
        // start and stop together: old held value
        send_request(32'd5, PRESSED, PRESSED);
        send_request(32'd6, RELEASED, RELEASED);
        // fresh start shows zero
        send_request(32'd100, PRESSED, RELEASED);
        // start held down, odd second
        send_request(32'd101, PRESSED, RELEASED);
        send_request(32'd200, RELEASED, RELEASED);
        // press again while running: start time kept, one hour
        send_request(32'd3700, PRESSED, RELEASED);
        // top of the display, then hours wrap past ninety-nine
        send_request(32'd359999 + 32'd100, RELEASED, RELEASED);
        send_request(32'd360000 + 32'd100, RELEASED, RELEASED);
        send_request(32'd363659 + 32'd100, RELEASED, RELEASED);
        // stop while running: held value, no new time
        send_request(32'd400, RELEASED, PRESSED);
        send_request(32'd500, RELEASED, RELEASED);
        // start just below the wrap of the seconds counter
        send_request(32'hFFFF_FFF0, PRESSED, RELEASED);
        send_request(32'h0000_0010, RELEASED, RELEASED);
        send_request(32'hFFFF_FFEF, RELEASED, RELEASED);
        send_request(32'hFFFF_FFFF, RELEASED, PRESSED);
        // start at all ones, same second
        send_request(32'hFFFF_FFFF, PRESSED, RELEASED);
        send_request(32'hFFFF_FFFF, RELEASED, RELEASED);
        send_request(32'hAAAA_AAAA, RELEASED, RELEASED);
        send_request(32'h5555_5555, RELEASED, PRESSED);

        run_phase(0, 0);
        run_phase(72, 0);
        run_phase(0, 72);
        run_phase(18, 18);

        // drain
        req_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ets_pkg.sv
design/ets_ctrl.sv
design/ets_fold.sv
design/ets_div.sv
design/elapsed_time_stopwatch.sv
tb/sv/elapsed_time_stopwatch_checker.sv
tb/sv/elapsed_time_stopwatch_tb.sv
